@@ hw/rtl/protobuf_wire_field_decoder_defines.svh @@
// Assertion helpers for the wire field decoder.
`ifndef PROTOBUF_WIRE_FIELD_DECODER_DEFINES_SVH
`define PROTOBUF_WIRE_FIELD_DECODER_DEFINES_SVH

// Condition holds on every clock out of reset.
`define PWFD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PWFD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/pwfd_pkg.sv @@
`default_nettype none

package pwfd_pkg;

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_VARINT  = 3'd1,
        PH_FIXED   = 3'd2,
        PH_LENHDR  = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_SCALAR  = 2'd0;
    localparam kind_t KIND_LENGTH  = 2'd1;
    localparam kind_t KIND_PAYLOAD = 2'd2;
    localparam kind_t KIND_ERROR   = 2'd3;

    typedef logic [1:0] err_t;
    localparam err_t ERR_NONE      = 2'd0;
    localparam err_t ERR_WIRE_TYPE = 2'd1;
    localparam err_t ERR_VARINT    = 2'd2;

    typedef logic [2:0] wire_t;
    localparam wire_t WIRE_VARINT  = 3'd0;
    localparam wire_t WIRE_FIXED64 = 3'd1;
    localparam wire_t WIRE_LENGTH  = 3'd2;
    localparam wire_t WIRE_FIXED32 = 3'd5;

    typedef enum logic {
        REG_SIGNED_VARINTS = 1'b0,
        REG_PAYLOAD_LIMIT  = 1'b1
    } cfg_reg_t;

    localparam logic [3:0]  VARINT_MAX_BYTES  = 4'd10;
    localparam logic [3:0]  FIXED64_BYTES     = 4'd8;
    localparam logic [3:0]  FIXED32_BYTES     = 4'd4;
    localparam logic [31:0] PAYLOAD_LIMIT_RST = 32'd64;

endpackage

`default_nettype wire

@@ hw/rtl/protobuf_wire_field_decoder.sv @@
`default_nettype none
`include "protobuf_wire_field_decoder_defines.svh"

// Protobuf wire-format field decoder. Takes one message byte per request and
// gives at most one result per byte: a scalar (varint, optionally zigzag,
// or little-endian fixed32/fixed64), a length header followed by one result
// per payload byte, or an error (group/unknown wire type, varint over ten
// bytes). Tag bytes give a result only on error. Sustains one byte per clock
// while out_stall is low; each byte is held in the input register, decoded by
// the per-byte logic, and its result held in the result register. in_stall
// rises only while both the input register and the result register hold
// requests and out_stall is high. Lengths saturate to 2^LENGTH_BITS - 1. The
// user must write configuration only while the block is idle (not enforced).
module protobuf_wire_field_decoder #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_index,
    input  wire logic [31:0]          cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 message_start,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output pwfd_pkg::kind_t           kind,
    output logic [28:0]               field_number,
    output pwfd_pkg::wire_t           wire_kind,
    output logic [63:0]               value,
    output logic [7:0]                data_byte,
    output logic                      last,
    output logic                      truncated,
    output pwfd_pkg::err_t            error_code
);

    import pwfd_pkg::*;

    localparam logic [63:0] LEN_MAX = (64'd1 << LENGTH_BITS) - 64'd1;

    // configuration
    logic                   signed_reg;
    logic [31:0]            limit_reg;

    // input register
    logic                   s1_valid_reg, s1_valid_next;
    logic [7:0]             s1_byte_reg;
    logic                   s1_start_reg;

    // decoder state
    phase_t                 phase_reg, phase_next;
    wire_t                  wire_reg, wire_next;
    logic [28:0]            field_reg, field_next;
    logic [63:0]            acc_reg, acc_next;
    logic [3:0]             bseen_reg, bseen_next;
    logic [LENGTH_BITS-1:0] remaining_reg, remaining_next;
    logic [32:0]            index_reg, index_next;

    // result register
    logic                   out_valid_reg, out_valid_next;
    kind_t                  kind_reg;
    logic [28:0]            field_out_reg;
    wire_t                  wire_out_reg;
    logic [63:0]            value_reg;
    logic [7:0]             data_reg;
    logic                   last_reg;
    logic                   trunc_reg;
    err_t                   err_reg;

    logic                   out_free;
    logic                   fire;
    logic                   accept;

    // decode terms
    phase_t                 ph;
    logic [63:0]            acc_base;
    logic [3:0]             bseen_base;
    logic [3:0]             bseen_inc;
    logic [6:0]             vshift;
    logic [63:0]            vacc;
    logic [63:0]            facc;
    logic                   cont;
    logic                   too_long;
    logic                   fdone;
    logic [63:0]            zz;
    logic [63:0]            len_sat;
    logic                   len_zero;
    logic                   pay_last;
    logic                   pay_trunc;
    wire_t                  tag_wire;

    // result of this byte
    logic                   emit;
    kind_t                  res_kind;
    logic [28:0]            res_field;
    wire_t                  res_wire;
    logic [63:0]            res_value;
    logic [7:0]             res_data;
    logic                   res_last;
    logic                   res_trunc;
    err_t                   res_err;

    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        ph         = s1_start_reg ? PH_TAG : phase_reg;
        acc_base   = s1_start_reg ? 64'd0 : acc_reg;
        bseen_base = s1_start_reg ? 4'd0 : bseen_reg;
        bseen_inc  = bseen_base + 4'd1;
        vshift     = 7'(bseen_base) * 7'd7;
        vacc       = acc_base | ({57'd0, s1_byte_reg[6:0]} << vshift);
        facc       = acc_base | ({56'd0, s1_byte_reg} << {bseen_base[2:0], 3'b000});
        cont       = s1_byte_reg[7];
        too_long   = cont && (bseen_inc >= VARINT_MAX_BYTES);
        fdone      = bseen_inc >= ((wire_reg == WIRE_FIXED64) ? FIXED64_BYTES
                                                             : FIXED32_BYTES);
        zz         = signed_reg ? ({1'b0, vacc[63:1]} ^ {64{vacc[0]}}) : vacc;
        len_sat    = (vacc > LEN_MAX) ? LEN_MAX : vacc;
        len_zero   = (vacc == 64'd0);
        pay_last   = (remaining_reg <= LENGTH_BITS'(1));
        pay_trunc  = (index_reg >= {1'b0, limit_reg});
        tag_wire   = vacc[2:0];
    end

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        wire_next      = wire_reg;
        field_next     = field_reg;
        acc_next       = acc_reg;
        bseen_next     = bseen_reg;
        remaining_next = remaining_reg;
        index_next     = index_reg;
        if (fire)
        begin
            phase_next = ph;
            acc_next   = acc_base;
            bseen_next = bseen_base;
            unique case (ph)
                PH_TAG:
                begin
                    if (cont && !too_long)
                    begin
                        acc_next   = vacc;
                        bseen_next = bseen_inc;
                    end
                    else if (too_long)
                    begin
                        field_next = '0;
                        wire_next  = WIRE_VARINT;
                        acc_next   = '0;
                        bseen_next = '0;
                    end
                    else
                    begin
                        field_next = vacc[31:3];
                        wire_next  = tag_wire;
                        acc_next   = '0;
                        bseen_next = '0;
                        case (tag_wire)
                            WIRE_VARINT:                phase_next = PH_VARINT;
                            WIRE_FIXED64, WIRE_FIXED32: phase_next = PH_FIXED;
                            WIRE_LENGTH:                phase_next = PH_LENHDR;
                            default:                    phase_next = PH_TAG;
                        endcase
                    end
                end
                PH_VARINT, PH_LENHDR:
                begin
                    if (cont && !too_long)
                    begin
                        acc_next   = vacc;
                        bseen_next = bseen_inc;
                    end
                    else
                    begin
                        acc_next   = '0;
                        bseen_next = '0;
                        phase_next = PH_TAG;
                        if (!too_long && ph == PH_LENHDR && !len_zero)
                        begin
                            remaining_next = len_sat[LENGTH_BITS-1:0];
                            index_next     = '0;
                            phase_next     = PH_PAYLOAD;
                        end
                    end
                end
                PH_FIXED:
                begin
                    if (fdone)
                    begin
                        acc_next   = '0;
                        bseen_next = '0;
                        phase_next = PH_TAG;
                    end
                    else
                    begin
                        acc_next   = facc;
                        bseen_next = bseen_inc;
                    end
                end
                PH_PAYLOAD:
                begin
                    index_next     = index_reg[32] ? index_reg : index_reg + 33'd1;
                    remaining_next = remaining_reg - LENGTH_BITS'(1);
                    if (pay_last)
                    begin
                        remaining_next = '0;
                        acc_next       = '0;
                        bseen_next     = '0;
                        phase_next     = PH_TAG;
                    end
                end
                default:
                begin
                    phase_next = PH_TAG;
                end
            endcase
        end
    end

    // result of the byte in the input register
    always_comb
    begin
        emit      = 1'b0;
        res_kind  = KIND_SCALAR;
        res_field = field_reg;
        res_wire  = wire_reg;
        res_value = '0;
        res_data  = '0;
        res_last  = 1'b0;
        res_trunc = 1'b0;
        res_err   = ERR_NONE;
        unique case (ph)
            PH_TAG:
            begin
                if (too_long)
                begin
                    emit      = 1'b1;
                    res_kind  = KIND_ERROR;
                    res_field = '0;
                    res_wire  = WIRE_VARINT;
                    res_err   = ERR_VARINT;
                end
                else if (!cont && tag_wire != WIRE_VARINT && tag_wire != WIRE_FIXED64
                         && tag_wire != WIRE_LENGTH && tag_wire != WIRE_FIXED32)
                begin
                    emit      = 1'b1;
                    res_kind  = KIND_ERROR;
                    res_field = vacc[31:3];
                    res_wire  = tag_wire;
                    res_err   = ERR_WIRE_TYPE;
                end
            end
            PH_VARINT, PH_LENHDR:
            begin
                if (too_long)
                begin
                    emit     = 1'b1;
                    res_kind = KIND_ERROR;
                    res_err  = ERR_VARINT;
                end
                else if (!cont)
                begin
                    emit = 1'b1;
                    if (ph == PH_VARINT)
                    begin
                        res_value = zz;
                    end
                    else
                    begin
                        res_kind  = KIND_LENGTH;
                        res_value = len_sat;
                        res_last  = len_zero;
                    end
                end
            end
            PH_FIXED:
            begin
                emit      = fdone;
                res_value = facc;
            end
            PH_PAYLOAD:
            begin
                emit      = 1'b1;
                res_kind  = KIND_PAYLOAD;
                res_data  = s1_byte_reg;
                res_last  = pay_last;
                res_trunc = pay_trunc;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign s1_valid_next  = accept || (s1_valid_reg && !fire);
    assign out_valid_next = fire ? emit : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_reg    <= 1'b0;
            limit_reg     <= PAYLOAD_LIMIT_RST;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_TAG;
            wire_reg      <= WIRE_VARINT;
            field_reg     <= '0;
            acc_reg       <= '0;
            bseen_reg     <= '0;
            remaining_reg <= '0;
            index_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_SIGNED_VARINTS: signed_reg <= cfg_data[0];
                    REG_PAYLOAD_LIMIT:  limit_reg  <= cfg_data;
                    default:            limit_reg  <= limit_reg;
                endcase
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            wire_reg      <= wire_next;
            field_reg     <= field_next;
            acc_reg       <= acc_next;
            bseen_reg     <= bseen_next;
            remaining_reg <= remaining_next;
            index_reg     <= index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg  <= in_byte;
            s1_start_reg <= message_start;
        end
        if (fire && emit)
        begin
            kind_reg      <= res_kind;
            field_out_reg <= res_field;
            wire_out_reg  <= res_wire;
            value_reg     <= res_value;
            data_reg      <= res_data;
            last_reg      <= res_last;
            trunc_reg     <= res_trunc;
            err_reg       <= res_err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign field_number = field_out_reg;
    assign wire_kind    = wire_out_reg;
    assign value        = value_reg;
    assign data_byte    = data_reg;
    assign last         = last_reg;
    assign truncated    = trunc_reg;
    assign error_code   = err_reg;

    `PWFD_ASSERT_ALWAYS(a_bseen_range, bseen_reg < VARINT_MAX_BYTES, "varint byte count overran")
    `PWFD_ASSERT_IMPLIES(a_payload_remaining, phase_reg == PH_PAYLOAD, remaining_reg != '0, "payload phase with nothing remaining")
    `PWFD_ASSERT_IMPLIES(a_fixed_wire, phase_reg == PH_FIXED, wire_reg == WIRE_FIXED64 || wire_reg == WIRE_FIXED32, "fixed phase with non-fixed wire type")
    `PWFD_ASSERT_IMPLIES(a_err_kind, out_valid_reg, (kind_reg == KIND_ERROR) == (err_reg != ERR_NONE), "error code and kind disagree")

endmodule

`default_nettype wire

@@ tb/wire_field_checker.sv @@
module wire_field_checker #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_wr_en,
    input  wire logic            cfg_index,
    input  wire logic [31:0]     cfg_data,
    input  wire logic            in_valid,
    input  wire logic            in_stall,
    input  wire logic [7:0]      in_byte,
    input  wire logic            message_start,
    input  wire logic            out_valid,
    input  wire logic            out_stall,
    input  wire pwfd_pkg::kind_t kind,
    input  wire logic [28:0]     field_number,
    input  wire pwfd_pkg::wire_t wire_kind,
    input  wire logic [63:0]     value,
    input  wire logic [7:0]      data_byte,
    input  wire logic            last,
    input  wire logic            truncated,
    input  wire pwfd_pkg::err_t  error_code,
    output int                   outstanding,
    output int                   fail_count
);

    import pwfd_pkg::*;

    localparam logic [63:0] LEN_MAX = (LENGTH_BITS >= 64) ? ~64'd0
                                    : ((64'd1 << LENGTH_BITS) - 64'd1);

    typedef struct packed {
        kind_t       kind;
        logic [28:0] field;
        wire_t       wtype;
        logic [63:0] value;
        logic [7:0]  data;
        logic        last;
        logic        trunc;
        err_t        err;
    } field_result_t;

    typedef enum {VARINT_MORE, VARINT_DONE, VARINT_OVERLONG} varint_status_t;

    field_result_t pending_fields[$];
    field_result_t want;
    field_result_t got;
    int            mismatches;

    logic          zigzag;
    logic [31:0]   limit;
    phase_t        ph;
    wire_t         cur_wire;
    logic [28:0]   cur_field;
    logic [63:0]   acc;
    logic [6:0]    shift_amt;
    logic [3:0]    nbytes;
    logic [63:0]   remaining;
    logic [63:0]   pidx;

    function automatic void clear_field();
        acc       = '0;
        shift_amt = '0;
        nbytes    = '0;
    endfunction

    function automatic field_result_t make_result(input kind_t k, input logic [63:0] v,
                                                  input logic [7:0] d, input logic l,
                                                  input logic t, input err_t e);
        field_result_t r;
        r.kind  = k;
        r.field = cur_field;
        r.wtype = cur_wire;
        r.value = v;
        r.data  = d;
        r.last  = l;
        r.trunc = t;
        r.err   = e;
        return r;
    endfunction

    function automatic varint_status_t absorb_varint(input logic [7:0] b);
        if (shift_amt < 7'd64)
            acc = acc | ({57'd0, b[6:0]} << shift_amt);
        shift_amt = shift_amt + 7'd7;
        nbytes    = nbytes + 4'd1;
        if (!b[7])
            return VARINT_DONE;
        if (nbytes >= VARINT_MAX_BYTES)
            return VARINT_OVERLONG;
        return VARINT_MORE;
    endfunction

    function automatic bit decode_wire_byte(input logic [7:0] b, input logic ms,
                                            output field_result_t res);
        varint_status_t st;
        logic [63:0]    v;
        logic [3:0]     need;
        logic           fin;
        res = '0;
        if (ms)
        begin
            ph = PH_TAG;
            clear_field();
        end
        case (ph)
            PH_VARINT, PH_LENHDR:
            begin
                st = absorb_varint(b);
                if (st == VARINT_MORE)
                    return 1'b0;
                if (st == VARINT_OVERLONG)
                begin
                    res = make_result(KIND_ERROR, '0, '0, 1'b0, 1'b0, ERR_VARINT);
                    ph = PH_TAG;
                    clear_field();
                    return 1'b1;
                end
                if (ph == PH_VARINT)
                begin
                    v = acc;
                    if (zigzag)
                        v = (v >> 1) ^ {64{v[0]}};
                    res = make_result(KIND_SCALAR, v, '0, 1'b0, 1'b0, ERR_NONE);
                    ph = PH_TAG;
                end
                else
                begin
                    v = (acc > LEN_MAX) ? LEN_MAX : acc;
                    if (v == 64'd0)
                    begin
                        res = make_result(KIND_LENGTH, '0, '0, 1'b1, 1'b0, ERR_NONE);
                        ph = PH_TAG;
                    end
                    else
                    begin
                        res = make_result(KIND_LENGTH, v, '0, 1'b0, 1'b0, ERR_NONE);
                        remaining = v;
                        pidx = '0;
                        ph = PH_PAYLOAD;
                    end
                end
                clear_field();
                return 1'b1;
            end
            PH_FIXED:
            begin
                need = (cur_wire == WIRE_FIXED64) ? FIXED64_BYTES : FIXED32_BYTES;
                acc = acc | ({56'd0, b} << {nbytes[2:0], 3'b000});
                nbytes = nbytes + 4'd1;
                if (nbytes < need)
                    return 1'b0;
                res = make_result(KIND_SCALAR, acc, '0, 1'b0, 1'b0, ERR_NONE);
                ph = PH_TAG;
                clear_field();
                return 1'b1;
            end
            PH_PAYLOAD:
            begin
                fin = (remaining <= 64'd1);
                res = make_result(KIND_PAYLOAD, '0, b, fin, pidx >= {32'd0, limit}, ERR_NONE);
                pidx = pidx + 64'd1;
                if (remaining != 64'd0)
                    remaining = remaining - 64'd1;
                if (fin)
                begin
                    ph = PH_TAG;
                    remaining = '0;
                    clear_field();
                end
                return 1'b1;
            end
            default:
            begin
                ph = PH_TAG;
                st = absorb_varint(b);
                if (st == VARINT_MORE)
                    return 1'b0;
                if (st == VARINT_OVERLONG)
                begin
                    cur_field = '0;
                    cur_wire  = '0;
                    res = make_result(KIND_ERROR, '0, '0, 1'b0, 1'b0, ERR_VARINT);
                    clear_field();
                    return 1'b1;
                end
                cur_field = acc[31:3];
                cur_wire  = acc[2:0];
                clear_field();
                case (cur_wire)
                    WIRE_VARINT:                ph = PH_VARINT;
                    WIRE_FIXED64, WIRE_FIXED32: ph = PH_FIXED;
                    WIRE_LENGTH:                ph = PH_LENHDR;
                    default:
                    begin
                        res = make_result(KIND_ERROR, '0, '0, 1'b0, 1'b0, ERR_WIRE_TYPE);
                        return 1'b1;
                    end
                endcase
                return 1'b0;
            end
        endcase
    endfunction

    task automatic compare_field(input string name, input logic [63:0] exp,
                                 input logic [63:0] act);
        if (exp !== act)
        begin
            mismatches++;
            $display("%0t %s mismatch: expected %h, actual %h", $time, name, exp, act);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zigzag      = 1'b0;
            limit       = PAYLOAD_LIMIT_RST;
            ph          = PH_TAG;
            cur_wire    = '0;
            cur_field   = '0;
            remaining   = '0;
            pidx        = '0;
            clear_field();
            pending_fields.delete();
            mismatches  = 0;
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_SIGNED_VARINTS: zigzag = cfg_data[0];
                    REG_PAYLOAD_LIMIT:  limit  = cfg_data;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (pending_fields.size() == 0)
                begin
                    mismatches++;
                    $display("%0t result mismatch: expected none, actual kind %0d value %h",
                             $time, kind, value);
                end
                else
                begin
                    want = pending_fields.pop_front();
                    compare_field("kind", 64'(want.kind), 64'(kind));
                    compare_field("field_number", 64'(want.field), 64'(field_number));
                    compare_field("wire_kind", 64'(want.wtype), 64'(wire_kind));
                    compare_field("value", want.value, value);
                    compare_field("data_byte", 64'(want.data), 64'(data_byte));
                    compare_field("last", 64'(want.last), 64'(last));
                    compare_field("truncated", 64'(want.trunc), 64'(truncated));
                    compare_field("error_code", 64'(want.err), 64'(error_code));
                end
            end
            if (in_valid && !in_stall)
            begin
                if (decode_wire_byte(in_byte, message_start, got))
                    pending_fields.push_back(got);
            end
            outstanding <= pending_fields.size();
            fail_count  <= mismatches;
        end
    end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    import pwfd_pkg::*;

    localparam int LEN_BITS       = 32;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 500;

    // wire types with no supported decoding
    localparam wire_t WIRE_GROUP_START = 3'd3;
    localparam wire_t WIRE_GROUP_END   = 3'd4;
    localparam wire_t WIRE_RSVD6       = 3'd6;
    localparam wire_t WIRE_RSVD7       = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        message_start;
    logic        out_valid;
    logic        out_stall;
    kind_t       kind;
    logic [28:0] field_number;
    wire_t       wire_kind;
    logic [63:0] value;
    logic [7:0]  data_byte;
    logic        last;
    logic        truncated;
    err_t        error_code;

    int          outstanding;
    int          fail_count;
    int          sent_bytes;
    int          idle_cycles;
    int          rx_hold;
    int          rx_draw;
    bit          rx_quiet;
    bit          tx_quiet;
    bit          next_start;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    protobuf_wire_field_decoder #(
        .LENGTH_BITS (LEN_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .message_start (message_start),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .field_number  (field_number),
        .wire_kind     (wire_kind),
        .value         (value),
        .data_byte     (data_byte),
        .last          (last),
        .truncated     (truncated),
        .error_code    (error_code)
    );

    wire_field_checker #(
        .LENGTH_BITS (LEN_BITS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .message_start (message_start),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .field_number  (field_number),
        .wire_kind     (wire_kind),
        .value         (value),
        .data_byte     (data_byte),
        .last          (last),
        .truncated     (truncated),
        .error_code    (error_code),
        .outstanding   (outstanding),
        .fail_count    (fail_count)
    );

    // result side: random stalls on offered results, with quiet stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_hold   <= 0;
            rx_quiet  <= 1'b0;
        end
        else if (out_stall)
        begin
            rx_hold <= rx_hold - 1;
            if (rx_hold <= 1)
                out_stall <= 1'b0;
        end
        else if (out_valid)
        begin
            if ($urandom_range(0, 99) == 0)
                rx_quiet <= !rx_quiet;
            rx_draw = rx_quiet ? 0 : $urandom_range(0, 3);
            if (rx_draw != 0)
            begin
                out_stall <= 1'b1;
                rx_hold   <= rx_draw;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_raw(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 99) == 0)
            tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_byte       <= b;
        message_start <= next_start;
        next_start = 1'b0;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_bytes++;
    endtask

    function automatic int pick_pad();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 9) : 0;
    endfunction

    // pad > 0 pads to at most ten bytes; a tenth byte gets junk above bit 63
    task automatic send_varint(input logic [63:0] v, input int pad);
        int         n;
        int         total;
        logic [7:0] bt;
        n = 1;
        while (n < 10 && (v >> (7 * n)) != 64'd0)
            n++;
        total = (n + pad > 10) ? 10 : n + pad;
        for (int i = 0; i < total; i++)
        begin
            bt = {1'b0, 7'(v >> (7 * i))};
            if (i == 9)
                bt[6:1] = 6'($urandom);
            if (i < total - 1)
                bt[7] = 1'b1;
            send_raw(bt);
        end
    endtask

    task automatic send_tag(input logic [60:0] f, input wire_t w, input int pad);
        send_varint({f, w}, pad);
    endtask

    task automatic send_overlong();
        repeat (10)
            send_raw(8'h80 | 8'($urandom_range(0, 127)));
    endtask

    function automatic logic [60:0] pick_field();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r < 7)
            return 61'($urandom_range(1, 15));
        if (r < 9)
            return 61'($urandom_range(0, 29'h1FFF_FFFF));
        return 61'({$urandom, $urandom});
    endfunction

    function automatic logic [63:0] pick_scalar();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return ~64'd0;
        return {$urandom, $urandom} >> $urandom_range(0, 63);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(0, 5);
        if (r < 9)
            return $urandom_range(6, 20);
        return $urandom_range(60, 70);
    endfunction

    task automatic send_field();
        int          pick;
        int          len;
        logic [60:0] fnum;
        wire_t       w;
        fnum = pick_field();
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            send_tag(fnum, WIRE_VARINT, pick_pad());
            send_varint(pick_scalar(), pick_pad());
        end
        else if (pick < 42)
        begin
            send_tag(fnum, WIRE_FIXED32, pick_pad());
            repeat (4) send_raw(8'($urandom));
        end
        else if (pick < 54)
        begin
            send_tag(fnum, WIRE_FIXED64, pick_pad());
            repeat (8) send_raw(8'($urandom));
        end
        else if (pick < 80)
        begin
            len = pick_len();
            send_tag(fnum, WIRE_LENGTH, pick_pad());
            send_varint(64'(len), pick_pad());
            repeat (len) send_raw(8'($urandom));
        end
        else if (pick < 84)
        begin
            // length past LENGTH_BITS saturates; cut it off with a new message
            send_tag(fnum, WIRE_LENGTH, 0);
            send_varint({$urandom, $urandom} | 64'h1_0000_0000, 0);
            repeat ($urandom_range(1, 4)) send_raw(8'($urandom));
            next_start = 1'b1;
        end
        else if (pick < 89)
        begin
            case ($urandom_range(0, 3))
                0:       w = WIRE_GROUP_START;
                1:       w = WIRE_GROUP_END;
                2:       w = WIRE_RSVD6;
                default: w = WIRE_RSVD7;
            endcase
            send_tag(fnum, w, pick_pad());
        end
        else if (pick < 93)
        begin
            if ($urandom_range(0, 1) != 0)
                send_tag(fnum, WIRE_VARINT, 0);
            send_overlong();
        end
        else if (pick < 97)
        begin
            // partial field dropped by message_start
            case ($urandom_range(0, 3))
                0:       w = WIRE_VARINT;
                1:       w = WIRE_FIXED32;
                2:       w = WIRE_FIXED64;
                default: w = WIRE_LENGTH;
            endcase
            send_tag(fnum, w, 0);
            repeat ($urandom_range(0, 3)) send_raw(8'($urandom));
            next_start = 1'b1;
        end
        else
        begin
            repeat ($urandom_range(1, 6)) send_raw(8'($urandom));
            next_start = 1'b1;
        end
    endtask

    task automatic run_messages(input int count);
        int stop;
        stop = sent_bytes + count;
        while (sent_bytes < stop)
        begin
            if ($urandom_range(0, 3) != 0)
                next_start = 1'b1;
            repeat ($urandom_range(1, 4)) send_field();
        end
    endtask

    // hold off requests until every predicted result is out and the pipe is empty
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic zz, input logic [31:0] lim);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SIGNED_VARINTS;
        cfg_data  <= {31'd0, zz};
        @(posedge clk);
        cfg_index <= REG_PAYLOAD_LIMIT;
        cfg_data  <= lim;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= REG_SIGNED_VARINTS;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        in_byte       <= '0;
        message_start <= 1'b0;
        sent_bytes = 0;
        tx_quiet   = 1'b0;
        next_start = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_tag(61'd1, WIRE_VARINT, 0);
        send_varint(64'd150, 0);
        send_tag(61'd2, WIRE_FIXED32, 0);
        send_raw(8'hFF);
        send_raw(8'h00);
        send_raw(8'h80);
        send_raw(8'h7F);
        send_tag(61'd3, WIRE_LENGTH, 0);
        send_varint(64'd0, 0);
        send_tag(61'd4, WIRE_LENGTH, 0);
        send_varint(64'd2, 0);
        send_raw(8'hFF);
        send_raw(8'h00);
        send_tag(61'd5, WIRE_GROUP_START, 0);
        send_tag(61'd6, WIRE_FIXED64, 0);
        repeat (8) send_raw(8'($urandom));
        settle();

        configure(1'b1, 32'd0);
        run_messages(330);
        settle();
        configure(1'b0, 32'd1);
        run_messages(330);
        settle();
        configure(1'b1, 32'd3);
        run_messages(330);
        settle();
        configure(1'b0, 32'hFFFF_FFFF);
        run_messages(330);
        settle();
        configure(1'b1, PAYLOAD_LIMIT_RST);
        run_messages(330);
        settle();
        configure(1'($urandom), 32'($urandom_range(0, 80)));
        run_messages(330);
        settle();

        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
